### design/itra_pkg.sv
// shared types, constants and helpers for integer_to_radix_ascii
// no dependencies; used by every module of the block

package itra_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int BASE_WIDTH  = 6;
	localparam int DIGIT_WIDTH = 6;
	localparam int CHAR_WIDTH  = 8;
	localparam int STEP_CNT_W  = $clog2(VALUE_WIDTH);
	localparam int STACK_CNT_W = $clog2(VALUE_WIDTH + 1);
	localparam int STACK_IDX_W = $clog2(VALUE_WIDTH);

	localparam logic [BASE_WIDTH-1:0] BASE_MIN = BASE_WIDTH'(2);
	localparam logic [BASE_WIDTH-1:0] BASE_MAX = BASE_WIDTH'(36);

	localparam logic [CHAR_WIDTH-1:0] CHAR_NUL   = 8'h00;
	localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2d;
	localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_WIDTH-1:0] CHAR_A     = 8'h61;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_POP,
		ST_NUL
	} state_t;

	// divider status seen by the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// digit stack controls from the sequencer
	typedef struct packed {
		logic                   push;
		logic                   pop;
		logic [DIGIT_WIDTH-1:0] data;
	} stack_ctrl_t;

	function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [DIGIT_WIDTH-1:0] d);
		logic [CHAR_WIDTH-1:0] d8;
		d8 = CHAR_WIDTH'(d);
		if (d < DIGIT_WIDTH'(10))
			return CHAR_ZERO + d8;
		else
			return CHAR_A + d8 - CHAR_WIDTH'(10);
	endfunction

endpackage

### design/integer_to_radix_ascii.sv
// Converts a signed 32-bit value to its text in a radix of 2 to 36 and sends it as ASCII
// characters, most significant first: an optional '-', the digits '0'-'9' and 'a'-'z',
// then a NUL that carries last. A radix outside 2..36 gives the NUL alone. One request is
// taken at a time and in_ready stays low until its NUL is in the output register. Each
// digit is computed on the shared one-bit-per-cycle divider, and every character then
// passes through the output register.
// top level; depends on itra_pkg, itra_div and itra_stack

module integer_to_radix_ascii (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [itra_pkg::VALUE_WIDTH-1:0] value,
	input  logic [itra_pkg::BASE_WIDTH-1:0]      base,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [itra_pkg::CHAR_WIDTH-1:0]      char_code,
	output logic                                 last
);

	itra_pkg::state_t                     state_q;
	itra_pkg::state_t                     state_d;
	logic                                 neg_q;
	logic                                 out_valid_q;
	logic [itra_pkg::CHAR_WIDTH-1:0]      char_q;
	logic                                 last_q;

	logic                                 accept;
	logic                                 base_ok;
	logic                                 out_free;
	logic [itra_pkg::VALUE_WIDTH-1:0]     mag;
	logic                                 div_start;
	logic [itra_pkg::VALUE_WIDTH-1:0]     div_dividend;
	logic [itra_pkg::VALUE_WIDTH-1:0]     quotient;
	logic [itra_pkg::DIGIT_WIDTH-1:0]     remainder;
	itra_pkg::div_stat_t                  div_stat;
	itra_pkg::stack_ctrl_t                stk_ctrl;
	logic [itra_pkg::DIGIT_WIDTH-1:0]     top_digit;
	logic [itra_pkg::STACK_CNT_W-1:0]     stk_count;
	logic                                 quo_zero;
	logic                                 out_load;
	logic [itra_pkg::CHAR_WIDTH-1:0]      out_char;
	logic                                 out_last;
	logic [itra_pkg::BASE_WIDTH-1:0]      base_q;

	assign accept   = in_valid && in_ready;
	assign base_ok  = base >= itra_pkg::BASE_MIN && base <= itra_pkg::BASE_MAX;
	assign out_free = !out_valid_q || out_ready;
	assign quo_zero = quotient == '0;

	// most negative value wraps to 2^(w-1), which is right as unsigned
	assign mag = value[itra_pkg::VALUE_WIDTH-1] ? (~value + 1'b1) : value;

	assign div_dividend = (state_q == itra_pkg::ST_IDLE) ? mag : quotient;

	itra_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   ((state_q == itra_pkg::ST_IDLE) ? base : base_q),
		.quotient  (quotient),
		.remainder (remainder),
		.stat      (div_stat)
	);

	itra_stack u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (stk_ctrl),
		.top_digit (top_digit),
		.count     (stk_count)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			itra_pkg::ST_IDLE: begin
				if (accept)
					state_d = base_ok ? itra_pkg::ST_DIV : itra_pkg::ST_NUL;
			end
			itra_pkg::ST_DIV: begin
				if (div_stat.done && quo_zero)
					state_d = neg_q ? itra_pkg::ST_SIGN : itra_pkg::ST_POP;
			end
			itra_pkg::ST_SIGN: begin
				if (out_free)
					state_d = itra_pkg::ST_POP;
			end
			itra_pkg::ST_POP: begin
				if (out_free && stk_count == itra_pkg::STACK_CNT_W'(1))
					state_d = itra_pkg::ST_NUL;
			end
			itra_pkg::ST_NUL: begin
				if (out_free)
					state_d = itra_pkg::ST_IDLE;
			end
			default: state_d = itra_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready      = 1'b0;
		div_start     = 1'b0;
		stk_ctrl.push = 1'b0;
		stk_ctrl.pop  = 1'b0;
		stk_ctrl.data = remainder;
		out_load      = 1'b0;
		out_char      = itra_pkg::CHAR_NUL;
		out_last      = 1'b0;
		unique case (state_q)
			itra_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				div_start = in_valid && base_ok;
			end
			itra_pkg::ST_DIV: begin
				stk_ctrl.push = div_stat.done;
				div_start     = div_stat.done && !quo_zero;
			end
			itra_pkg::ST_SIGN: begin
				out_load = out_free;
				out_char = itra_pkg::CHAR_MINUS;
			end
			itra_pkg::ST_POP: begin
				out_load     = out_free;
				stk_ctrl.pop = out_free;
				out_char     = itra_pkg::digit_char(top_digit);
			end
			itra_pkg::ST_NUL: begin
				out_load = out_free;
				out_char = itra_pkg::CHAR_NUL;
				out_last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= itra_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q  <= value[itra_pkg::VALUE_WIDTH-1];
			base_q <= base;
		end
		if (out_load) begin
			char_q <= out_char;
			last_q <= out_last;
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last      = last_q;

	a_last_is_nul: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && last_q |-> char_q == itra_pkg::CHAR_NUL)
		else $error("last set on a character other than the terminator");

	a_stack_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == itra_pkg::ST_IDLE |-> stk_count == '0 && !div_stat.busy)
		else $error("leftover digits or divider run at end of request");

endmodule

### design/itra_div.sv
// iterative restoring divider: one quotient bit per cycle
// unsigned magnitude by a small radix; depends on itra_pkg

module itra_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [itra_pkg::VALUE_WIDTH-1:0]     dividend,
	input  logic [itra_pkg::BASE_WIDTH-1:0]      divisor,
	output logic [itra_pkg::VALUE_WIDTH-1:0]     quotient,
	output logic [itra_pkg::DIGIT_WIDTH-1:0]     remainder,
	output itra_pkg::div_stat_t                  stat
);

	logic                                busy_q;
	logic                                done_q;
	logic [itra_pkg::STEP_CNT_W-1:0]     cnt_q;
	logic [itra_pkg::VALUE_WIDTH-1:0]    quo_q;
	logic [itra_pkg::DIGIT_WIDTH-1:0]    rem_q;
	logic [itra_pkg::BASE_WIDTH-1:0]     div_q;
	logic [itra_pkg::DIGIT_WIDTH:0]      trial;
	logic                                fits;

	// shift in the next dividend bit and try the subtract
	assign trial = {rem_q, quo_q[itra_pkg::VALUE_WIDTH-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == itra_pkg::STEP_CNT_W'(itra_pkg::VALUE_WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[itra_pkg::VALUE_WIDTH-2:0], fits};
			rem_q <= fits ? itra_pkg::DIGIT_WIDTH'(trial - {1'b0, div_q})
			              : trial[itra_pkg::DIGIT_WIDTH-1:0];
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("divider done without a finished run");

endmodule

### design/itra_stack.sv
// digit stack: remainders go in least significant first and come out reversed
// depends on itra_pkg

module itra_stack (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  itra_pkg::stack_ctrl_t                ctrl,
	output logic [itra_pkg::DIGIT_WIDTH-1:0]     top_digit,
	output logic [itra_pkg::STACK_CNT_W-1:0]     count
);

	logic [itra_pkg::DIGIT_WIDTH-1:0] mem [itra_pkg::VALUE_WIDTH];
	logic [itra_pkg::STACK_CNT_W-1:0] cnt_q;
	logic [itra_pkg::DIGIT_WIDTH-1:0] top_q;
	logic [itra_pkg::STACK_CNT_W-1:0] below_ptr;

	// entry under the current top, which becomes the top after a pop
	assign below_ptr = cnt_q - itra_pkg::STACK_CNT_W'(2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (ctrl.push)
			cnt_q <= cnt_q + 1'b1;
		else if (ctrl.pop)
			cnt_q <= cnt_q - 1'b1;
	end

	// top entry kept in a register so a pop only needs the entry below it
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[cnt_q[itra_pkg::STACK_IDX_W-1:0]] <= ctrl.data;
			top_q <= ctrl.data;
		end else if (ctrl.pop) begin
			top_q <= mem[below_ptr[itra_pkg::STACK_IDX_W-1:0]];
		end
	end

	assign top_digit = top_q;
	assign count     = cnt_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.push |-> cnt_q < itra_pkg::STACK_CNT_W'(itra_pkg::VALUE_WIDTH))
		else $error("digit stack overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |-> cnt_q != '0 && !ctrl.push)
		else $error("digit stack underflow");

endmodule
